// ----- rtl/fplw_pkg.sv -----
// ----------------------------------------------------------------------------
// fplw_pkg
// Shared constants, codes and controller/datapath interface types for the
// fixed-point line walker.
// ----------------------------------------------------------------------------
package fplw_pkg;

	localparam int FRACTION_BITS_DEF  = 16;
	localparam int COORD_BITS_DEF     = 12;
	localparam int MAX_LINE_WIDTH_DEF = 32;

	localparam int PIX_W   = 14;  // output pixel coordinate
	localparam int CFG_W   = 13;  // image size registers
	localparam int ANGLE_W = 16;  // Q1.15 cosine / sine
	localparam int MAG_W   = 17;  // magnitude of a negated Q1.15 value
	localparam int LW_W    = 6;   // line width

	localparam logic REG_IMAGE_WIDTH  = 1'b0;
	localparam logic REG_IMAGE_HEIGHT = 1'b1;

	localparam logic ACT_START = 1'b0;
	localparam logic ACT_REPLY = 1'b1;

	typedef struct packed {
		logic load;
		logic div_step;
		logic div_round;
		logic side_init;
		logic side_emit;
		logic step;
		logic centre_emit;
		logic done_emit;
	} cmd_t;

	typedef struct packed {
		logic div_last;
		logic active;
		logic width_gt1;
		logic side_last;
		logic out_free;
	} sts_t;

endpackage

// ----- rtl/fplw_ctrl.sv -----
// ----------------------------------------------------------------------------
// fplw_ctrl
// Sequencer for the line walker: input handshake, slope division steps,
// side pixel loop, advance and centre/done emission.
// ----------------------------------------------------------------------------
module fplw_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic          action,
	input  logic          stop_reply,
	input  fplw_pkg::sts_t sts,
	output fplw_pkg::cmd_t cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DIV    = 3'd1;
	localparam logic [2:0] S_ROUND  = 3'd2;
	localparam logic [2:0] S_CENTRE = 3'd3;
	localparam logic [2:0] S_DONE   = 3'd4;
	localparam logic [2:0] S_SIDE   = 3'd5;
	localparam logic [2:0] S_STEP   = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       accept;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (action == fplw_pkg::ACT_START) begin
						cmd.load = 1'b1;
						state_d  = S_DIV;
					end else if (!sts.active || stop_reply) begin
						state_d = S_DONE;
					end else if (sts.width_gt1) begin
						cmd.side_init = 1'b1;
						state_d       = S_SIDE;
					end else begin
						state_d = S_STEP;
					end
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = S_ROUND;
				end
			end
			S_ROUND: begin
				cmd.div_round = 1'b1;
				state_d       = S_CENTRE;
			end
			S_CENTRE: begin
				if (sts.out_free) begin
					cmd.centre_emit = 1'b1;
					state_d         = S_IDLE;
				end
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.done_emit = 1'b1;
					state_d       = S_IDLE;
				end
			end
			S_SIDE: begin
				if (sts.out_free) begin
					cmd.side_emit = 1'b1;
					if (sts.side_last) begin
						state_d = S_STEP;
					end
				end
			end
			S_STEP: begin
				cmd.step = 1'b1;
				state_d  = S_CENTRE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	emit_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.side_emit || cmd.centre_emit || cmd.done_emit) |-> sts.out_free)
		else $error("emit without free output register");

	one_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.side_emit, cmd.centre_emit, cmd.done_emit, cmd.load}))
		else $error("conflicting emit commands");

	div_to_round: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV && sts.div_last) |=> (state_q == S_ROUND))
		else $error("division did not finish into rounding");

endmodule

// ----- rtl/fplw_dpath.sv -----
// ----------------------------------------------------------------------------
// fplw_dpath
// Walk state, bit-serial slope divider, side pixel counter, bound check,
// image size registers and the output register.
// ----------------------------------------------------------------------------
module fplw_dpath #(
	parameter int FRACTION_BITS  = fplw_pkg::FRACTION_BITS_DEF,
	parameter int COORD_BITS     = fplw_pkg::COORD_BITS_DEF,
	parameter int MAX_LINE_WIDTH = fplw_pkg::MAX_LINE_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_write_en,
	input  logic                               cfg_index,
	input  logic [fplw_pkg::CFG_W-1:0]         cfg_data,
	input  logic [COORD_BITS-1:0]              start_x,
	input  logic [COORD_BITS-1:0]              start_y,
	input  logic signed [fplw_pkg::ANGLE_W-1:0] cos_value,
	input  logic signed [fplw_pkg::ANGLE_W-1:0] sin_value,
	input  logic                               forward,
	input  logic [fplw_pkg::LW_W-1:0]          line_width,
	input  fplw_pkg::cmd_t                     cmd,
	output fplw_pkg::sts_t                     sts,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [fplw_pkg::PIX_W-1:0]  pixel_x,
	output logic signed [fplw_pkg::PIX_W-1:0]  pixel_y,
	output logic                               is_centre,
	output logic                               walk_done,
	output logic                               last
);

	localparam int POS_W   = (COORD_BITS + 1 > fplw_pkg::PIX_W) ? COORD_BITS + 1
	                                                             : fplw_pkg::PIX_W;
	localparam int MINOR_W = POS_W + FRACTION_BITS;
	localparam int INC_W   = FRACTION_BITS + 2;
	localparam int QUO_W   = FRACTION_BITS + 1;
	localparam int CNT_W   = $clog2(FRACTION_BITS + 1);
	localparam int CMP_W   = POS_W + 1;
	localparam int MAG_W   = fplw_pkg::MAG_W;
	localparam int LW_W    = fplw_pkg::LW_W;
	localparam logic [FRACTION_BITS-1:0] HALF = {1'b1, {(FRACTION_BITS-1){1'b0}}};

	// image size
	logic [fplw_pkg::CFG_W-1:0] img_w_q;
	logic [fplw_pkg::CFG_W-1:0] img_h_q;

	// walk state
	logic                      active_q;
	logic                      xmaj_q;
	logic signed [POS_W-1:0]   major_q;
	logic signed [MINOR_W-1:0] minor_q;
	logic                      dir_q;
	logic signed [INC_W-1:0]   inc_q;
	logic [LW_W-1:0]           width_q;

	// divider
	logic [MAG_W:0]   rem_q;
	logic [MAG_W-1:0] den_q;
	logic [QUO_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             neg_q;
	logic             zero_q;

	// side loop
	logic [LW_W-1:0] k_q;
	logic            minus_q;

	// output register
	logic                             out_valid_q;
	logic signed [fplw_pkg::PIX_W-1:0] px_q;
	logic signed [fplw_pkg::PIX_W-1:0] py_q;
	logic                             centre_q;
	logic                             done_q;
	logic                             last_q;

	// start decode
	logic signed [MAG_W-1:0] c_ext;
	logic signed [MAG_W-1:0] s_neg;
	logic [MAG_W-1:0]        ac;
	logic [MAG_W-1:0]        as_mag;
	logic                    c_pos;
	logic                    s_pos;
	logic                    xmaj_ld;
	logic [POS_W-1:0]        sx_ext;
	logic [POS_W-1:0]        sy_ext;
	logic [LW_W-1:0]         width_ld;

	assign c_ext   = MAG_W'(cos_value);
	assign s_neg   = -MAG_W'(sin_value);
	assign ac      = c_ext[MAG_W-1] ? MAG_W'(-c_ext) : MAG_W'(c_ext);
	assign as_mag  = s_neg[MAG_W-1] ? MAG_W'(-s_neg) : MAG_W'(s_neg);
	assign c_pos   = !c_ext[MAG_W-1] && (c_ext != '0);
	assign s_pos   = !s_neg[MAG_W-1] && (s_neg != '0);
	assign xmaj_ld = as_mag > ac;
	assign sx_ext  = {{(POS_W-COORD_BITS){1'b0}}, start_x};
	assign sy_ext  = {{(POS_W-COORD_BITS){1'b0}}, start_y};
	assign width_ld = (line_width > LW_W'(MAX_LINE_WIDTH)) ? LW_W'(MAX_LINE_WIDTH)
	                                                      : line_width;

	// divider step and rounding
	logic [MAG_W:0]          rem_sh;
	logic                    rem_ge;
	logic [MAG_W:0]          rem2;
	logic                    round_up;
	logic [QUO_W-1:0]        quo_rnd;
	logic signed [INC_W-1:0] inc_mag;

	assign rem_sh   = (cnt_q == '0) ? rem_q : {rem_q[MAG_W-1:0], 1'b0};
	assign rem_ge   = rem_sh >= {1'b0, den_q};
	assign rem2     = {rem_q[MAG_W-1:0], 1'b0};
	assign round_up = (rem2 > {1'b0, den_q}) || ((rem2 == {1'b0, den_q}) && quo_q[0]);
	assign quo_rnd  = quo_q + QUO_W'(round_up);
	assign inc_mag  = {1'b0, quo_rnd};

	// pixel positions
	logic signed [POS_W-1:0] minor_pix;
	logic signed [POS_W-1:0] cx;
	logic signed [POS_W-1:0] cy;
	logic signed [POS_W-1:0] side_minor;
	logic                    in_image;

	assign minor_pix  = minor_q[MINOR_W-1:FRACTION_BITS];
	assign cx         = xmaj_q ? major_q : minor_pix;
	assign cy         = xmaj_q ? minor_pix : major_q;
	assign side_minor = minus_q ? minor_pix - POS_W'(k_q) : minor_pix + POS_W'(k_q);
	assign in_image   = !cx[POS_W-1] && !cy[POS_W-1]
	                 && ($signed({cx[POS_W-1], cx}) < $signed(CMP_W'(img_w_q)))
	                 && ($signed({cy[POS_W-1], cy}) < $signed(CMP_W'(img_h_q)));

	assign sts.div_last  = (cnt_q == CNT_W'(FRACTION_BITS));
	assign sts.active    = active_q;
	assign sts.width_gt1 = (width_q > LW_W'(1));
	assign sts.side_last = minus_q && (k_q == width_q - LW_W'(1));
	assign sts.out_free  = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_w_q     <= fplw_pkg::CFG_W'(640);
			img_h_q     <= fplw_pkg::CFG_W'(480);
			active_q    <= 1'b0;
			xmaj_q      <= 1'b0;
			major_q     <= '0;
			minor_q     <= '0;
			dir_q       <= 1'b0;
			inc_q       <= '0;
			width_q     <= LW_W'(1);
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_write_en) begin
				unique case (cfg_index)
					fplw_pkg::REG_IMAGE_WIDTH:  img_w_q <= cfg_data;
					fplw_pkg::REG_IMAGE_HEIGHT: img_h_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.load) begin
				xmaj_q  <= xmaj_ld;
				major_q <= xmaj_ld ? sx_ext : sy_ext;
				minor_q <= {(xmaj_ld ? sy_ext : sx_ext), HALF};
				dir_q   <= (xmaj_ld ? !s_pos : !c_pos) ^ !forward;
				width_q <= width_ld;
			end
			if (cmd.div_round) begin
				inc_q <= zero_q ? '0 : (neg_q ? -inc_mag : inc_mag);
			end
			if (cmd.step) begin
				major_q <= dir_q ? major_q - POS_W'(1) : major_q + POS_W'(1);
				minor_q <= minor_q + {{(MINOR_W-INC_W){inc_q[INC_W-1]}}, inc_q};
			end
			if (cmd.centre_emit) begin
				active_q <= in_image;
			end else if (cmd.done_emit) begin
				active_q <= 1'b0;
			end
			if (cmd.side_emit || cmd.centre_emit || cmd.done_emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rem_q  <= {1'b0, (xmaj_ld ? ac : as_mag)};
			den_q  <= xmaj_ld ? as_mag : ac;
			zero_q <= !xmaj_ld && (ac == '0);
			neg_q  <= (xmaj_ld ? c_ext[MAG_W-1] : s_neg[MAG_W-1]) ^ !forward;
			quo_q  <= '0;
			cnt_q  <= '0;
		end else if (cmd.div_step) begin
			rem_q <= rem_ge ? rem_sh - {1'b0, den_q} : rem_sh;
			quo_q <= {quo_q[QUO_W-2:0], rem_ge};
			cnt_q <= cnt_q + CNT_W'(1);
		end
		if (cmd.side_init) begin
			k_q     <= LW_W'(1);
			minus_q <= 1'b0;
		end else if (cmd.side_emit) begin
			minus_q <= !minus_q;
			if (minus_q) begin
				k_q <= k_q + LW_W'(1);
			end
		end
		if (cmd.side_emit) begin
			px_q     <= fplw_pkg::PIX_W'(xmaj_q ? major_q : side_minor);
			py_q     <= fplw_pkg::PIX_W'(xmaj_q ? side_minor : major_q);
			centre_q <= 1'b0;
			done_q   <= 1'b0;
			last_q   <= 1'b0;
		end else if (cmd.centre_emit) begin
			px_q     <= in_image ? fplw_pkg::PIX_W'(cx) : '0;
			py_q     <= in_image ? fplw_pkg::PIX_W'(cy) : '0;
			centre_q <= in_image;
			done_q   <= !in_image;
			last_q   <= 1'b1;
		end else if (cmd.done_emit) begin
			px_q     <= '0;
			py_q     <= '0;
			centre_q <= 1'b0;
			done_q   <= 1'b1;
			last_q   <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign pixel_x   = px_q;
	assign pixel_y   = py_q;
	assign is_centre = centre_q;
	assign walk_done = done_q;
	assign last      = last_q;

	last_marks_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (last_q == (centre_q || done_q)))
		else $error("last flag does not match word kind");

	centre_xor_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(centre_q && done_q))
		else $error("word is both centre and done");

	centre_sets_active: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.centre_emit |=> (active_q == centre_q))
		else $error("walk state disagrees with emitted centre");

endmodule

// ----- rtl/fixed_point_line_walker.sv -----
// ----------------------------------------------------------------------------
// fixed_point_line_walker
// Walks a line given by a start pixel and Hough normal angle with a
// fixed-point DDA, emitting centre pixels and perpendicular width pixels.
//
// Input channel (in_valid/in_stall): one word per command. A start word
// sets up the walk and yields one result, the first centre pixel or a done
// word when the start lies outside the image. A reply word answers the last
// centre pixel: stop, or a reply with no walk running, yields one done word;
// go on yields 2*(width-1) side pixels, then the next centre or a done word
// at the image border. The final word of each command carries last.
// Output channel (out_valid/out_stall): one registered output word.
// Sequence: a start runs the bit-serial slope divider, then rounding, then
// the centre word. A go-on reply emits its side pixels, then the advance and
// the centre word; a done reply goes straight to its done word. Each command
// is first taken in the idle state. One command is in flight at a time.
// While the receiver stalls, the output word holds and the walk waits on it.
// Reset: idle, no walk, image 640 by 480, width 1.
// ----------------------------------------------------------------------------
module fixed_point_line_walker #(
	parameter int FRACTION_BITS  = fplw_pkg::FRACTION_BITS_DEF,
	parameter int COORD_BITS     = fplw_pkg::COORD_BITS_DEF,
	parameter int MAX_LINE_WIDTH = fplw_pkg::MAX_LINE_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write_en,
	input  logic                                cfg_index,
	input  logic [fplw_pkg::CFG_W-1:0]          cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                action,
	input  logic [COORD_BITS-1:0]               start_x,
	input  logic [COORD_BITS-1:0]               start_y,
	input  logic signed [fplw_pkg::ANGLE_W-1:0] cos_value,
	input  logic signed [fplw_pkg::ANGLE_W-1:0] sin_value,
	input  logic                                forward,
	input  logic [fplw_pkg::LW_W-1:0]           line_width,
	input  logic                                stop_reply,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [fplw_pkg::PIX_W-1:0]   pixel_x,
	output logic signed [fplw_pkg::PIX_W-1:0]   pixel_y,
	output logic                                is_centre,
	output logic                                walk_done,
	output logic                                last
);

	fplw_pkg::cmd_t cmd;
	fplw_pkg::sts_t sts;

	fplw_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.action     (action),
		.stop_reply (stop_reply),
		.sts        (sts),
		.cmd        (cmd)
	);

	fplw_dpath #(
		.FRACTION_BITS  (FRACTION_BITS),
		.COORD_BITS     (COORD_BITS),
		.MAX_LINE_WIDTH (MAX_LINE_WIDTH)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.start_x      (start_x),
		.start_y      (start_y),
		.cos_value    (cos_value),
		.sin_value    (sin_value),
		.forward      (forward),
		.line_width   (line_width),
		.cmd          (cmd),
		.sts          (sts),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.is_centre    (is_centre),
		.walk_done    (walk_done),
		.last         (last)
	);

endmodule

// ----- verif/fixed_point_line_walker_test.sv -----
// ----------------------------------------------------------------------------
// fixed_point_line_walker_test
// Self-checking bench for the line walker. Start and reply words go in
// through the valid/stall input channel. A behavioral DDA tracks the walk
// state and queues the pixel words each accepted word should produce. The
// output checker compares every received word field by field against that
// queue. Directed corner cases come first, then random walks over several
// image sizes, with random idle and stall bursts except in the final stretch.
// ----------------------------------------------------------------------------
module fixed_point_line_walker_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC        = fplw_pkg::FRACTION_BITS_DEF;
	localparam int MAXW        = fplw_pkg::MAX_LINE_WIDTH_DEF;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE      = 40;
	localparam int PRINT_CAP   = 100;

	typedef struct packed {
		logic signed [fplw_pkg::PIX_W-1:0] px;
		logic signed [fplw_pkg::PIX_W-1:0] py;
		logic                              centre;
		logic                              done;
		logic                              lst;
	} pixel_word_t;

	logic                                clk          = 1'b0;
	logic                                arst_n       = 1'b0;
	logic                                cfg_write_en = 1'b0;
	logic                                cfg_index    = fplw_pkg::REG_IMAGE_WIDTH;
	logic [fplw_pkg::CFG_W-1:0]          cfg_data     = '0;
	logic                                in_valid     = 1'b0;
	logic                                in_stall;
	logic                                action       = fplw_pkg::ACT_START;
	logic [fplw_pkg::COORD_BITS_DEF-1:0] start_x      = '0;
	logic [fplw_pkg::COORD_BITS_DEF-1:0] start_y      = '0;
	logic signed [fplw_pkg::ANGLE_W-1:0] cos_value    = '0;
	logic signed [fplw_pkg::ANGLE_W-1:0] sin_value    = '0;
	logic                                forward      = 1'b0;
	logic [fplw_pkg::LW_W-1:0]           line_width   = '0;
	logic                                stop_reply   = 1'b0;
	logic                                out_valid;
	logic                                out_stall    = 1'b0;
	logic signed [fplw_pkg::PIX_W-1:0]   pixel_x;
	logic signed [fplw_pkg::PIX_W-1:0]   pixel_y;
	logic                                is_centre;
	logic                                walk_done;
	logic                                last;

	// walk tracking
	bit          walk_on    = 1'b0;
	bit          along_x    = 1'b0;
	int          major_pos  = 0;
	longint      minor_fix  = 0;
	bit          step_back  = 1'b0;
	longint      minor_inc  = 0;
	int          side_count = 1;
	int          img_w      = 640;
	int          img_h      = 480;

	pixel_word_t expected_pixels[$];
	pixel_word_t head_word;
	int          mismatches = 0;
	int          cycles     = 0;
	bit          idle_on    = 1'b1;
	int          stall_left = 0;

	fixed_point_line_walker i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.action       (action),
		.start_x      (start_x),
		.start_y      (start_y),
		.cos_value    (cos_value),
		.sin_value    (sin_value),
		.forward      (forward),
		.line_width   (line_width),
		.stop_reply   (stop_reply),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.is_centre    (is_centre),
		.walk_done    (walk_done),
		.last         (last)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAIL fixed_point_line_walker");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (!idle_on) begin
			stall_left <= 0;
			out_stall  <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall  <= 1'b1;
		end else if ($urandom_range(0, 9) == 0) begin
			stall_left <= $urandom_range(0, 18);
			out_stall  <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	task automatic report_mismatch(string what, int got, int want);
		mismatches++;
		if (mismatches <= PRINT_CAP)
			$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_pixels.size() == 0) begin
				report_mismatch("unexpected word", int'($signed(pixel_x)), 0);
			end else begin
				head_word = expected_pixels.pop_front();
				if (pixel_x !== head_word.px)
					report_mismatch("pixel_x", int'($signed(pixel_x)), int'(head_word.px));
				if (pixel_y !== head_word.py)
					report_mismatch("pixel_y", int'($signed(pixel_y)), int'(head_word.py));
				if (is_centre !== head_word.centre)
					report_mismatch("is_centre", int'(is_centre), int'(head_word.centre));
				if (walk_done !== head_word.done)
					report_mismatch("walk_done", int'(walk_done), int'(head_word.done));
				if (last !== head_word.lst)
					report_mismatch("last", int'(last), int'(head_word.lst));
			end
		end
	end

	task automatic emit_pixel(longint x, longint y, bit centre, bit done);
		pixel_word_t w;
		w.px     = x[fplw_pkg::PIX_W-1:0];
		w.py     = y[fplw_pkg::PIX_W-1:0];
		w.centre = centre;
		w.done   = done;
		w.lst    = 1'b0;
		expected_pixels.push_back(w);
	endtask

	task automatic emit_centre_or_done();
		longint minor, x, y;
		minor = minor_fix >>> FRAC;
		x = along_x ? longint'(major_pos) : minor;
		y = along_x ? minor : longint'(major_pos);
		if (x < 0 || x >= img_w || y < 0 || y >= img_h) begin
			walk_on = 1'b0;
			emit_pixel(0, 0, 1'b0, 1'b1);
		end else begin
			walk_on = 1'b1;
			emit_pixel(x, y, 1'b1, 1'b0);
		end
	endtask

	function automatic longint nearest_div(longint num, longint den);
		longint mag, q, r;
		mag = num < 0 ? -num : num;
		q = mag / den;
		r = mag % den;
		if (2 * r > den || (2 * r == den && q[0]))
			q++;
		return num < 0 ? -q : q;
	endfunction

	task automatic predict_word(bit act, logic [11:0] sx, logic [11:0] sy,
			logic [15:0] cv, logic [15:0] sv, bit fwd, logic [5:0] lw, bit stp);
		longint c, s, mag_c, mag_s, minor, x, y, half;
		pixel_word_t tail;
		half = longint'(1) <<< (FRAC - 1);
		if (act == fplw_pkg::ACT_START) begin
			c = longint'($signed(cv));
			s = -longint'($signed(sv));
			mag_c = c < 0 ? -c : c;
			mag_s = s < 0 ? -s : s;
			along_x = mag_s > mag_c;
			if (along_x) begin
				major_pos = int'(sx);
				minor_fix = (longint'(sy) <<< FRAC) + half;
				step_back = !(s > 0);
				minor_inc = nearest_div(c <<< FRAC, mag_s);
			end else begin
				major_pos = int'(sy);
				minor_fix = (longint'(sx) <<< FRAC) + half;
				step_back = !(c > 0);
				minor_inc = mag_c != 0 ? nearest_div(s <<< FRAC, mag_c) : 0;
			end
			if (!fwd) begin
				step_back = !step_back;
				minor_inc = -minor_inc;
			end
			side_count = int'(lw) > MAXW ? MAXW : int'(lw);
			emit_centre_or_done();
		end else if (!walk_on) begin
			emit_pixel(0, 0, 1'b0, 1'b1);
		end else if (stp) begin
			walk_on = 1'b0;
			emit_pixel(0, 0, 1'b0, 1'b1);
		end else begin
			minor = minor_fix >>> FRAC;
			x = along_x ? longint'(major_pos) : minor;
			y = along_x ? minor : longint'(major_pos);
			for (int k = 1; k < side_count; k++) begin
				if (along_x) begin
					emit_pixel(x, y + k, 1'b0, 1'b0);
					emit_pixel(x, y - k, 1'b0, 1'b0);
				end else begin
					emit_pixel(x + k, y, 1'b0, 1'b0);
					emit_pixel(x - k, y, 1'b0, 1'b0);
				end
			end
			major_pos += step_back ? -1 : 1;
			minor_fix += minor_inc;
			emit_centre_or_done();
		end
		tail = expected_pixels.pop_back();
		tail.lst = 1'b1;
		expected_pixels.push_back(tail);
	endtask

	task automatic send_word(bit act, logic [11:0] sx, logic [11:0] sy,
			logic [15:0] cv, logic [15:0] sv, bit fwd, logic [5:0] lw, bit stp);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		in_valid   <= 1'b1;
		action     <= act;
		start_x    <= sx;
		start_y    <= sy;
		cos_value  <= cv;
		sin_value  <= sv;
		forward    <= fwd;
		line_width <= lw;
		stop_reply <= stp;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_word(act, sx, sy, cv, sv, fwd, lw, stp);
	endtask

	task automatic start_walk(logic [11:0] sx, logic [11:0] sy, logic [15:0] cv,
			logic [15:0] sv, bit fwd, logic [5:0] lw);
		send_word(fplw_pkg::ACT_START, sx, sy, cv, sv, fwd, lw, 1'($urandom));
	endtask

	task automatic reply_walk(bit stp);
		send_word(fplw_pkg::ACT_REPLY, 12'($urandom), 12'($urandom), 16'($urandom),
			16'($urandom), 1'($urandom), 6'($urandom), stp);
	endtask

	task automatic wait_quiet();
		in_valid <= 1'b0;
		while (expected_pixels.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_image(int w, int h);
		cfg_write_en <= 1'b1;
		cfg_index    <= fplw_pkg::REG_IMAGE_WIDTH;
		cfg_data     <= w[fplw_pkg::CFG_W-1:0];
		@(posedge clk);
		img_w = w & 32'h1fff;
		cfg_index <= fplw_pkg::REG_IMAGE_HEIGHT;
		cfg_data  <= h[fplw_pkg::CFG_W-1:0];
		@(posedge clk);
		img_h = h & 32'h1fff;
		cfg_write_en <= 1'b0;
	endtask

	function automatic logic [15:0] pick_angle();
		case ($urandom_range(0, 7))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			3: return 16'($urandom_range(1, 8));
			4: return -16'($urandom_range(1, 8));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [5:0] pick_width();
		case ($urandom_range(0, 7))
			6: return 6'($urandom_range(0, 63));
			7: return 6'($urandom_range(30, 63));
			default: return 6'($urandom_range(1, 3));
		endcase
	endfunction

	task automatic random_walks(int words);
		int r;
		logic [11:0] sx, sy;
		repeat (words) begin
			r = $urandom_range(0, 19);
			if (!walk_on && r == 0) begin
				reply_walk(1'($urandom));
			end else if (!walk_on || r == 1) begin
				if ($urandom_range(0, 7) == 0) begin
					sx = 12'($urandom);
					sy = 12'($urandom);
				end else begin
					sx = 12'($urandom_range(0, img_w - 1));
					sy = 12'($urandom_range(0, img_h - 1));
				end
				start_walk(sx, sy, pick_angle(), pick_angle(), 1'($urandom), pick_width());
			end else begin
				reply_walk(r == 2 || r == 3);
			end
		end
	endtask

	task automatic test_directed();
		reply_walk(1'b0);
		start_walk(12'd0, 12'd0, 16'h7fff, 16'h0000, 1'b1, 6'd32);
		reply_walk(1'b0);
		reply_walk(1'b1);
		start_walk(12'd320, 12'd240, 16'h8000, 16'h8000, 1'b0, 6'd63);
		reply_walk(1'b0);
		// restart while a walk is running
		start_walk(12'd100, 12'd200, 16'h0000, 16'h7fff, 1'b1, 6'd0);
		reply_walk(1'b0);
		start_walk(12'd5, 12'd5, 16'h0000, 16'h0000, 1'b0, 6'd1);
		reply_walk(1'b0);
		start_walk(12'hfff, 12'hfff, 16'h1234, 16'hedcb, 1'b1, 6'd3);
		reply_walk(1'b0);
		start_walk(12'd639, 12'd479, 16'h0000, 16'h8001, 1'b1, 6'd4);
		reply_walk(1'b0);
		start_walk(12'd0, 12'd0, 16'h8000, 16'h7fff, 1'b1, 6'd2);
		reply_walk(1'b0);
		start_walk(12'd10, 12'd10, 16'h4000, 16'hc000, 1'b1, 6'd33);
		reply_walk(1'b0);
		reply_walk(1'b1);
	endtask

	task automatic test_image_extremes();
		wait_quiet();
		set_image(1, 1);
		start_walk(12'd0, 12'd0, pick_angle(), pick_angle(), 1'b1, 6'd3);
		reply_walk(1'b0);
		start_walk(12'd0, 12'd1, 16'h7fff, 16'h0000, 1'b1, 6'd2);
		wait_quiet();
		set_image(4096, 4096);
		start_walk(12'hfff, 12'hfff, 16'h7fff, 16'h0000, 1'b1, 6'd32);
		reply_walk(1'b0);
	endtask

	task automatic test_random_walks();
		wait_quiet();
		set_image(640, 480);
		random_walks(18);
		wait_quiet();
		set_image(16, 12);
		random_walks(20);
		wait_quiet();
		set_image(4096, 4096);
		random_walks(14);
		wait_quiet();
		set_image($urandom_range(1, 64), $urandom_range(1, 64));
		random_walks(20);
		wait_quiet();
		set_image(4096, 3);
		random_walks(14);
	endtask

	task automatic test_no_idle();
		wait_quiet();
		idle_on = 1'b0;
		set_image(24, 20);
		random_walks(20);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_directed();
		test_image_extremes();
		test_random_walks();
		test_no_idle();
		wait_quiet();
		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0)
			$display("PASS fixed_point_line_walker");
		else
			$display("FAIL fixed_point_line_walker");
		$finish;
	end

endmodule
